[design/vna_pkg.sv]
package vna_pkg;

  localparam int COORD_BITS = 16;
  localparam int QDEPTH     = 4;

  localparam logic [1:0] FUNC_WRITE  = 2'd0;
  localparam logic [1:0] FUNC_TRI    = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_TRI,
    OP_READ,
    OP_READ_BAD
  } op_t;

  typedef struct packed {
    logic [1:0]                   func;
    logic [9:0]                   vertex_index;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic [9:0]                   corner_a;
    logic [9:0]                   corner_b;
    logic [9:0]                   corner_c;
  } request_t;

  typedef struct packed {
    logic [9:0]   normal_vertex;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic         zero_length;
  } result_t;

  typedef struct packed {
    op_t                          op;
    logic [9:0]                   vertex_index;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic [9:0]                   corner_a;
    logic [9:0]                   corner_b;
    logic [9:0]                   corner_c;
  } cmd_t;

  typedef struct packed {
    logic take;
    logic clearing;
  } back_ctl_t;

endpackage

[design/vertex_normal_accumulator.sv]
// Area-weighted vertex normal accumulator. A write item stores a Q3.12
// position and clears that vertex's sum; a triangle item adds the edge cross
// product to its three corners with saturation; a read item returns the
// Q1.14 unit normal. Items queue in a four-deep command queue and run one at
// a time in the engine: a triangle makes three position reads then a
// read-modify-write per corner through the accumulator's read and write ports,
// and a read of a nonzero sum takes up to 29 one-bit normalising shifts, a
// 32-step square root and a 16-step divider shared by the three components.
// After reset a clearing pass zeroes every accumulator; full stays high
// meanwhile.
module vertex_normal_accumulator #(
  parameter int MAX_VERTICES = 1024,
  parameter int ACC_BITS     = 40
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  vna_pkg::request_t request,
  output logic              empty,
  input  logic              pop,
  output vna_pkg::result_t  result
);
  import vna_pkg::*;

  back_ctl_t ctl;
  logic      cmd_valid;
  cmd_t      cmd;

  vna_front #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .request  (request),
    .ctl      (ctl),
    .cmd_valid(cmd_valid),
    .cmd      (cmd)
  );

  vna_back #(
    .MAX_VERTICES(MAX_VERTICES),
    .ACC_BITS    (ACC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .ctl      (ctl),
    .result   (result),
    .empty    (empty),
    .pop      (pop)
  );

endmodule

[design/vna_front.sv]
module vna_front #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  vna_pkg::request_t  request,
  input  vna_pkg::back_ctl_t ctl,
  output logic               cmd_valid,
  output vna_pkg::cmd_t      cmd
);
  import vna_pkg::*;

  localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  cmd_t           q_mem [QDEPTH];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [QAW:0]   count;

  logic  keep;
  logic  enq;
  logic  deq;
  cmd_t  cls;
  logic  ok_v, ok_a, ok_b, ok_c;

  assign ok_v = 32'(request.vertex_index) < MAX_VERTICES;
  assign ok_a = 32'(request.corner_a) < MAX_VERTICES;
  assign ok_b = 32'(request.corner_b) < MAX_VERTICES;
  assign ok_c = 32'(request.corner_c) < MAX_VERTICES;

  always_comb begin
    cls.vertex_index = request.vertex_index;
    cls.pos_x        = request.pos_x;
    cls.pos_y        = request.pos_y;
    cls.pos_z        = request.pos_z;
    cls.corner_a     = request.corner_a;
    cls.corner_b     = request.corner_b;
    cls.corner_c     = request.corner_c;
    cls.op           = OP_WRITE;
    keep             = 1'b0;
    case (request.func)
      FUNC_WRITE: begin
        cls.op = OP_WRITE;
        keep   = ok_v;
      end
      FUNC_TRI: begin
        cls.op = OP_TRI;
        keep   = ok_a && ok_b && ok_c;
      end
      FUNC_READ: begin
        cls.op = ok_v ? OP_READ : OP_READ_BAD;
        keep   = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign full      = (count == (QAW+1)'(QDEPTH)) || ctl.clearing;
  assign enq       = push && !full && keep;
  assign deq       = ctl.take;
  assign cmd_valid = count != '0;
  assign cmd       = q_mem[rptr];

  always_ff @(posedge clk) begin
    if (enq) begin
      q_mem[wptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (enq) begin
        wptr <= (wptr == QAW'(QDEPTH-1)) ? '0 : wptr + 1'b1;
      end
      if (deq) begin
        rptr <= (rptr == QAW'(QDEPTH-1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (QAW+1)'(enq) - (QAW+1)'(deq);
    end
  end

endmodule

[design/vna_back.sv]
module vna_back #(
  parameter int MAX_VERTICES = 1024,
  parameter int ACC_BITS     = 40
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  vna_pkg::cmd_t       cmd,
  output vna_pkg::back_ctl_t  ctl,
  output vna_pkg::result_t    result,
  output logic                empty,
  input  logic                pop
);
  import vna_pkg::*;

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CB = COORD_BITS;
  localparam int EW = CB + 1;
  localparam int PW = 2 * CB + 2;
  localparam int NB = 2 * CB + 3;
  localparam int SW = ((ACC_BITS > NB) ? ACC_BITS : NB) + 1;
  localparam int A  = ACC_BITS;
  localparam logic signed [SW-1:0] ACC_HI = {{(SW-A+1){1'b0}}, {(A-1){1'b1}}};
  localparam logic signed [SW-1:0] ACC_LO = {{(SW-A+1){1'b1}}, {(A-1){1'b0}}};
  localparam logic [15:0] UNIT = 16'd16384;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_TP1, S_TP2, S_TP3, S_TMUL, S_TSUB, S_ARD, S_AWR,
    S_RMAG, S_RMAX, S_NORM, S_SQ, S_SUM, S_SQRT, S_DIV, S_DIVL, S_DSTORE, S_OUT
  } state_t;

  state_t state;

  logic [3*CB-1:0] pos_mem [MAX_VERTICES];
  logic [3*A-1:0]  acc_mem [MAX_VERTICES];

  logic [AW-1:0]   pos_ra;
  logic [3*CB-1:0] pos_q;
  logic [AW-1:0]   acc_ra;
  logic [3*A-1:0]  acc_q;
  logic            acc_we;
  logic [AW-1:0]   acc_wa;
  logic [3*A-1:0]  acc_wd;
  logic            pos_we;

  logic [AW-1:0]   clr;
  logic [AW-1:0]   corner0, corner1, corner2, corner_k;
  logic [1:0]      k;
  logic [3*CB-1:0] p0, p1;
  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];
  logic signed [PW-1:0] prod [6];
  logic signed [NB-1:0] n [3];

  logic [9:0]      rvertex;
  logic [A-1:0]    m [3];
  logic [2:0]      neg;
  logic [A-1:0]    mx;
  logic [59:0]     sq [3];
  logic [63:0]     sv, root, bitm;
  logic [1:0]      comp;
  logic [45:0]     rem, dvs;
  logic [15:0]     q;
  logic [3:0]      cnt;
  logic [15:0]     qc;
  logic signed [15:0] comp_out [3];
  logic            zero;
  logic            res_full;
  logic            load;
  logic            take;

  function automatic logic [A-1:0] sat_add(input logic signed [A-1:0] a,
                                           input logic signed [NB-1:0] b);
    logic signed [SW-1:0] s;
    s = SW'(a) + SW'(b);
    if (s > ACC_HI) begin
      s = ACC_HI;
    end else if (s < ACC_LO) begin
      s = ACC_LO;
    end
    return s[A-1:0];
  endfunction

  function automatic logic [A-1:0] magn(input logic [A-1:0] v);
    return v[A-1] ? (~v + 1'b1) : v;
  endfunction

  assign take         = (state == S_IDLE) && cmd_valid;
  assign ctl.take     = take;
  assign ctl.clearing = state == S_CLEAR;
  assign load         = (state == S_OUT) && (!res_full || pop);
  assign empty        = !res_full;

  always_comb begin
    case (k)
      2'd0:    corner_k = corner0;
      2'd1:    corner_k = corner1;
      default: corner_k = corner2;
    endcase
  end

  always_comb begin
    pos_ra = AW'(cmd.corner_a);
    acc_ra = AW'(cmd.vertex_index);
    acc_we = 1'b0;
    acc_wa = AW'(cmd.vertex_index);
    acc_wd = '0;
    pos_we = 1'b0;
    case (state)
      S_CLEAR: begin
        acc_we = 1'b1;
        acc_wa = clr;
      end
      S_IDLE: begin
        if (take && cmd.op == OP_WRITE) begin
          acc_we = 1'b1;
          pos_we = 1'b1;
        end
      end
      S_TP1: pos_ra = corner1;
      S_TP2: pos_ra = corner2;
      S_ARD: acc_ra = corner_k;
      S_AWR: begin
        acc_we = 1'b1;
        acc_wa = corner_k;
        acc_wd = {sat_add(acc_q[2*A +: A], n[2]),
                  sat_add(acc_q[A +: A], n[1]),
                  sat_add(acc_q[0 +: A], n[0])};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[AW'(cmd.vertex_index)] <= {cmd.pos_z, cmd.pos_y, cmd.pos_x};
    end
    pos_q <= pos_mem[pos_ra];
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_wa] <= acc_wd;
    end
    acc_q <= acc_mem[acc_ra];
  end

  assign qc = (q > UNIT) ? UNIT : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr      <= '0;
      res_full <= 1'b0;
    end else begin
      if (load) begin
        res_full <= 1'b1;
      end else if (pop) begin
        res_full <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (clr == AW'(MAX_VERTICES-1)) begin
            state <= S_IDLE;
          end else begin
            clr <= clr + 1'b1;
          end
        end
        S_IDLE: begin
          if (take) begin
            corner0 <= AW'(cmd.corner_a);
            corner1 <= AW'(cmd.corner_b);
            corner2 <= AW'(cmd.corner_c);
            rvertex <= cmd.vertex_index;
            case (cmd.op)
              OP_TRI:  state <= S_TP1;
              OP_READ: state <= S_RMAG;
              OP_READ_BAD: begin
                zero        <= 1'b1;
                comp_out[0] <= '0;
                comp_out[1] <= '0;
                comp_out[2] <= '0;
                state       <= S_OUT;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_TP1: begin
          p0    <= pos_q;
          state <= S_TP2;
        end
        S_TP2: begin
          p1    <= pos_q;
          state <= S_TP3;
        end
        S_TP3: begin
          for (int i = 0; i < 3; i++) begin
            e1[i] <= EW'($signed(p1[i*CB +: CB])) - EW'($signed(p0[i*CB +: CB]));
            e2[i] <= EW'($signed(pos_q[i*CB +: CB])) - EW'($signed(p0[i*CB +: CB]));
          end
          state <= S_TMUL;
        end
        S_TMUL: begin
          prod[0] <= e1[1] * e2[2];
          prod[1] <= e1[2] * e2[1];
          prod[2] <= e1[2] * e2[0];
          prod[3] <= e1[0] * e2[2];
          prod[4] <= e1[0] * e2[1];
          prod[5] <= e1[1] * e2[0];
          state   <= S_TSUB;
        end
        S_TSUB: begin
          n[0]  <= NB'(prod[0]) - NB'(prod[1]);
          n[1]  <= NB'(prod[2]) - NB'(prod[3]);
          n[2]  <= NB'(prod[4]) - NB'(prod[5]);
          k     <= 2'd0;
          state <= S_ARD;
        end
        S_ARD: state <= S_AWR;
        S_AWR: begin
          if (k == 2'd2) begin
            state <= S_IDLE;
          end else begin
            k     <= k + 1'b1;
            state <= S_ARD;
          end
        end
        S_RMAG: begin
          for (int i = 0; i < 3; i++) begin
            m[i]   <= magn(acc_q[i*A +: A]);
            neg[i] <= acc_q[i*A + A - 1];
          end
          state <= S_RMAX;
        end
        S_RMAX: begin
          if (m[0] >= m[1] && m[0] >= m[2]) begin
            mx <= m[0];
          end else if (m[1] >= m[2]) begin
            mx <= m[1];
          end else begin
            mx <= m[2];
          end
          state <= S_NORM;
        end
        S_NORM: begin
          if (mx == '0) begin
            zero        <= 1'b1;
            comp_out[0] <= '0;
            comp_out[1] <= '0;
            comp_out[2] <= '0;
            state       <= S_OUT;
          end else if (mx[A-1:30] != '0) begin
            mx <= mx >> 1;
            for (int i = 0; i < 3; i++) m[i] <= m[i] >> 1;
          end else if (mx[A-1:29] == '0) begin
            mx <= mx << 1;
            for (int i = 0; i < 3; i++) m[i] <= m[i] << 1;
          end else begin
            state <= S_SQ;
          end
        end
        S_SQ: begin
          for (int i = 0; i < 3; i++) sq[i] <= m[i][29:0] * m[i][29:0];
          state <= S_SUM;
        end
        S_SUM: begin
          sv    <= 64'(sq[0]) + 64'(sq[1]) + 64'(sq[2]);
          root  <= '0;
          bitm  <= 64'd1 << 62;
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (sv >= root + bitm) begin
            sv   <= sv - (root + bitm);
            root <= (root >> 1) + bitm;
          end else begin
            root <= root >> 1;
          end
          bitm <= bitm >> 2;
          if (bitm[0]) begin
            comp  <= 2'd0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem   <= 46'({m[comp][29:0], 14'b0}) + 46'(root[31:1]);
          dvs   <= 46'(root[30:0]) << 15;
          q     <= '0;
          cnt   <= 4'd15;
          state <= S_DIVL;
        end
        S_DIVL: begin
          if (rem >= dvs) begin
            rem <= rem - dvs;
            q   <= {q[14:0], 1'b1};
          end else begin
            q   <= {q[14:0], 1'b0};
          end
          dvs <= dvs >> 1;
          cnt <= cnt - 1'b1;
          if (cnt == 4'd0) begin
            state <= S_DSTORE;
          end
        end
        S_DSTORE: begin
          comp_out[comp] <= neg[comp] ? -$signed(qc) : $signed(qc);
          if (comp == 2'd2) begin
            zero  <= 1'b0;
            state <= S_OUT;
          end else begin
            comp  <= comp + 1'b1;
            state <= S_DIV;
          end
        end
        S_OUT: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.normal_vertex <= rvertex;
      result.normal_x      <= comp_out[0];
      result.normal_y      <= comp_out[1];
      result.normal_z      <= comp_out[2];
      result.zero_length   <= zero;
    end
  end

  a_no_take_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !take)
    else $error("command taken during clearing pass");

  a_root_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (root >= (64'd1 << 29) && root < (64'd1 << 31)))
    else $error("square root outside normalised range");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (res_full && !pop) |=> res_full)
    else $error("waiting result lost");

  a_fell_pop: assert property (@(posedge clk) disable iff (rst)
    $fell(res_full) |-> $past(pop))
    else $error("result dropped without pop");

endmodule

[tb/sv/vertex_normal_accumulator_tb.sv]
module vertex_normal_accumulator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vna_pkg::*;

  localparam int NVERT = 1024;
  localparam int ACCW = 40;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full;
  logic empty;
  request_t request = '0;
  result_t result;

  vertex_normal_accumulator dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .request(request),
    .empty(empty), .pop(pop), .result(result)
  );

  always #2 clk = ~clk;

  // predictor state
  logic signed [COORD_BITS-1:0] vpos [NVERT][3];
  longint vsum [NVERT][3];
  bit written [NVERT];
  int written_list[$];
  result_t expected_normals[$];

  int errors = 0;
  int cycle = 0;
  int last_accept = 0;
  bit hold_go = 0;

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle - last_accept > IDLE_LIMIT) begin
      $display("%0t timeout: no item accepted for %0d cycles", $realtime, IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic longint sat_acc(longint a, longint b);
    longint hi, lo, s;
    hi = (longint'(1) <<< (ACCW - 1)) - 1;
    lo = -hi - 1;
    s = a + b;
    if (s > hi) return hi;
    if (s < lo) return lo;
    return s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic result_t unit_normal(logic [9:0] vi);
    result_t e;
    longint unsigned m[3];
    longint unsigned mx, sq, len, q;
    logic [15:0] comp[3];
    e = '0;
    e.normal_vertex = vi;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = vsum[vi][i] < 0 ? longint'(-vsum[vi][i]) : vsum[vi][i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      e.zero_length = 1'b1;
      return e;
    end
    while (mx >= (64'd1 << 30)) begin
      mx = mx >> 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx = mx << 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
    end
    sq = 0;
    for (int i = 0; i < 3; i++) sq = sq + m[i] * m[i];
    len = int_sqrt(sq);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * 16384 + (len >> 1)) / len;
      if (q > 16384) q = 16384;
      comp[i] = q[15:0];
      if (vsum[vi][i] < 0) comp[i] = -comp[i];
    end
    e.normal_x = comp[0];
    e.normal_y = comp[1];
    e.normal_z = comp[2];
    return e;
  endfunction

  task automatic predict_item(request_t r);
    longint e1[3], e2[3], n[3];
    logic [9:0] c[3];
    case (r.func)
      FUNC_WRITE: begin
        vpos[r.vertex_index][0] = r.pos_x;
        vpos[r.vertex_index][1] = r.pos_y;
        vpos[r.vertex_index][2] = r.pos_z;
        for (int i = 0; i < 3; i++) vsum[r.vertex_index][i] = 0;
        if (!written[r.vertex_index]) written_list = {written_list, int'(r.vertex_index)};
        written[r.vertex_index] = 1;
      end
      FUNC_TRI: begin
        c[0] = r.corner_a; c[1] = r.corner_b; c[2] = r.corner_c;
        for (int i = 0; i < 3; i++) begin
          e1[i] = longint'(vpos[c[1]][i]) - longint'(vpos[c[0]][i]);
          e2[i] = longint'(vpos[c[2]][i]) - longint'(vpos[c[0]][i]);
        end
        n[0] = e1[1] * e2[2] - e1[2] * e2[1];
        n[1] = e1[2] * e2[0] - e1[0] * e2[2];
        n[2] = e1[0] * e2[1] - e1[1] * e2[0];
        for (int k = 0; k < 3; k++)
          for (int i = 0; i < 3; i++) vsum[c[k]][i] = sat_acc(vsum[c[k]][i], n[i]);
      end
      FUNC_READ: expected_normals = {expected_normals, unit_normal(r.vertex_index)};
      default: ;
    endcase
  endtask

  task automatic send_item(request_t r);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    request <= r;
    do @(posedge clk); while (full);
    last_accept = cycle;
    predict_item(r);
  endtask

  task automatic drain;
    push <= 1'b0;
    do @(posedge clk); while (expected_normals.size() != 0);
  endtask

  function automatic request_t mk_write(int vi, int x, int y, int z);
    request_t r;
    r = '0;
    r.func = FUNC_WRITE;
    r.vertex_index = 10'(vi);
    r.pos_x = 16'(x); r.pos_y = 16'(y); r.pos_z = 16'(z);
    r.corner_a = 10'($urandom); r.corner_b = 10'($urandom); r.corner_c = 10'($urandom);
    return r;
  endfunction

  function automatic request_t mk_tri(int a, int b, int c);
    request_t r;
    r = '0;
    r.func = FUNC_TRI;
    r.vertex_index = 10'($urandom);
    r.pos_x = 16'($urandom); r.pos_y = 16'($urandom); r.pos_z = 16'($urandom);
    r.corner_a = 10'(a); r.corner_b = 10'(b); r.corner_c = 10'(c);
    return r;
  endfunction

  function automatic request_t mk_read(int vi);
    request_t r;
    r = mk_tri(0, 0, 0);
    r.func = FUNC_READ;
    r.vertex_index = 10'(vi);
    return r;
  endfunction

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t %s mismatch: expected %0d actual %0d", $realtime, name, exp_v, act_v);
    end
  endtask

  // result side
  initial begin
    int stall;
    result_t e;
    @(negedge rst);
    @(posedge clk);
    pop <= 1'b1;
    forever begin
      do @(posedge clk); while (empty);
      last_accept = cycle;
      if (expected_normals.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none actual %h", $realtime, result);
      end else begin
        e = expected_normals.pop_front();
        check_field("normal_vertex", e.normal_vertex, result.normal_vertex);
        check_field("normal_x", e.normal_x, result.normal_x);
        check_field("normal_y", e.normal_y, result.normal_y);
        check_field("normal_z", e.normal_z, result.normal_z);
        check_field("zero_length", e.zero_length, result.zero_length);
      end
      stall = hold_go ? HOLD_CYCLES : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 5));
      hold_go = 0;
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
        pop <= 1'b1;
      end
    end
  end

  task automatic test_directed;
    request_t r;
    send_item(mk_write(0, 0, 0, 0));
    send_item(mk_write(1, 'h1000, 0, 0));
    send_item(mk_write(2, 0, 'h1000, 0));
    send_item(mk_tri(0, 1, 2));
    send_item(mk_read(0));
    send_item(mk_read(1));
    send_item(mk_read(2));
    send_item(mk_write(3, 32767, 32767, 32767));
    send_item(mk_write(4, -32768, -32768, -32768));
    send_item(mk_write(5, 32767, -32768, 0));
    send_item(mk_tri(3, 4, 5));
    send_item(mk_tri(3, 3, 4));
    send_item(mk_tri(5, 3, 3));
    send_item(mk_tri(4, 5, 5));
    send_item(mk_read(3));
    send_item(mk_read(4));
    send_item(mk_read(5));
    send_item(mk_read(1023));
    send_item(mk_write(1023, -1, 1, -32768));
    send_item(mk_read(1023));
    r = mk_tri($urandom, $urandom, $urandom);
    r.func = FUNC_UNUSED;
    r.vertex_index = 10'($urandom);
    send_item(r);
    send_item(mk_write(0, 5, 0, 0));
    send_item(mk_read(0));
  endtask

  // drives the z accumulators of three vertices to the high rail, then to the low rail
  task automatic test_saturation;
    send_item(mk_write(10, -32768, -32768, 0));
    send_item(mk_write(11, 32767, -32768, 0));
    send_item(mk_write(12, -32768, 32767, 0));
    for (int i = 0; i < 140; i++) send_item(mk_tri(10, 11, 12));
    send_item(mk_read(10));
    send_item(mk_read(11));
    for (int i = 0; i < 300; i++) send_item(mk_tri(10, 12, 11));
    send_item(mk_read(12));
    drain();
  endtask

  task automatic test_backpressure;
    hold_go = 1;
    for (int i = 0; i < 14; i++) send_item(mk_read(i % 6));
    drain();
  endtask

  task automatic test_random(int count);
    int sel, a, b, c, pick;
    request_t r;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (i == count / 2) drain();
      if (sel < 25 || written_list.size() < 3) begin
        pick = $urandom_range(0, 1) ? $urandom_range(0, 31) : $urandom_range(0, NVERT - 1);
        send_item(mk_write(pick, $urandom, $urandom, $urandom));
      end else if (sel < 65) begin
        a = written_list[$urandom_range(0, written_list.size() - 1)];
        b = written_list[$urandom_range(0, written_list.size() - 1)];
        c = written_list[$urandom_range(0, written_list.size() - 1)];
        if ($urandom_range(0, 9) == 0) b = a;
        send_item(mk_tri(a, b, c));
      end else if (sel < 95) begin
        if ($urandom_range(0, 3) == 0) send_item(mk_read($urandom_range(0, NVERT - 1)));
        else send_item(mk_read(written_list[$urandom_range(0, written_list.size() - 1)]));
      end else begin
        r = mk_tri($urandom, $urandom, $urandom);
        r.func = FUNC_UNUSED;
        r.vertex_index = 10'($urandom);
        send_item(r);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < NVERT; i++)
      for (int k = 0; k < 3; k++) begin
        vpos[i][k] = '0;
        vsum[i][k] = 0;
      end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_saturation();
    test_backpressure();
    test_random(370);
    push <= 1'b0;
    do @(posedge clk); while (expected_normals.size() != 0);
    repeat (300) @(posedge clk);
    if (errors == 0 && expected_normals.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
design/vna_pkg.sv
design/vna_front.sv
design/vna_back.sv
design/vertex_normal_accumulator.sv
tb/sv/vertex_normal_accumulator_tb.sv
